// File: rtl/core/rgblab_pkg.sv
// ----------------------------------------------------------------------------
// rgblab_pkg
// Shared types and fixed constants of the RGB to l-alpha-beta log converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rgblab_pkg;

    localparam int NUM_CH      = 3;
    localparam int CH_W        = 8;
    localparam int LATENCY     = 12;
    localparam int LANE_STAGES = 8;

    localparam int SUM_W  = 22;
    localparam int T_W    = 34;
    localparam int QP_W   = 47;
    localparam int QE_W   = 17;
    localparam int DP_W   = 35;
    localparam int LMS_W  = 16;
    localparam int POS_W  = 4;
    localparam int FRAC_W = 15;
    localparam int ROM_W  = 21;
    localparam int Q_FRAC = 20;
    localparam int L2_W   = 26;
    localparam int LP_W   = 46;
    localparam int LG_W   = 24;
    localparam int MXS_W  = 26;
    localparam int MIX_W  = 47;
    localparam int OUT_W  = 16;

    localparam int T_SH     = 12;
    localparam int TRUNC_SH = 10;
    localparam int RECIP_SH = 30;

    typedef logic [SUM_W-1:0]         sum_t;
    typedef logic [T_W-1:0]           tnum_t;
    typedef logic [QP_W-1:0]          qprod_t;
    typedef logic [QE_W-1:0]          qe_t;
    typedef logic [DP_W-1:0]          dprod_t;
    typedef logic [LMS_W-1:0]         lms_t;
    typedef logic [POS_W-1:0]         pos_t;
    typedef logic [FRAC_W-1:0]        frac_t;
    typedef logic [ROM_W-1:0]         rom_t;
    typedef logic signed [L2_W-1:0]   l2_t;
    typedef logic signed [LP_W-1:0]   lp_t;
    typedef logic signed [LG_W-1:0]   lg_t;
    typedef logic signed [MXS_W-1:0]  mxs_t;
    typedef logic signed [MIX_W-1:0]  mix_t;
    typedef logic signed [OUT_W-1:0]  out_t;
    typedef logic [13:0]              coef_t;
    typedef logic signed [ROM_W-1:0]  mcoef_t;

    // rows L, M, S; columns red, green, blue; in ten-thousandths
    localparam coef_t LMS_COEF [NUM_CH][NUM_CH] = '{
        '{14'd3811, 14'd5783, 14'd402},
        '{14'd1967, 14'd7244, 14'd782},
        '{14'd241,  14'd1288, 14'd8444}
    };

    // LMS = floor((4096 * sum + DIV_OFS) / DIV_D)
    localparam tnum_t  DIV_OFS   = 34'd79687;
    localparam dprod_t DIV_D     = 35'd159375;
    localparam qprod_t DIV_RECIP = 47'd6898896;

    localparam lms_t FLOOR_RESET = 16'd4588;
    localparam lms_t LMS_MAX     = 16'hFFFF;
    localparam rom_t ROM_ONE     = 21'h100000;

    localparam mcoef_t LOG10_2_Q20 = 21'sd315653;
    localparam mcoef_t MIX_COEF [NUM_CH] = '{21'sd605396, 21'sd428079, 21'sd741455};

    localparam out_t OUT_MAX = 16'sh7FFF;
    localparam out_t OUT_MIN = -16'sh8000;

    function automatic rom_t log2_rom_entry(input int unsigned idx,
                                            input int unsigned tbl_bits);
        logic [63:0] y;
        rom_t        res;
        res = '0;
        if (idx >= (32'd1 << tbl_bits)) begin
            res = ROM_ONE;
        end
        else begin
            y = (64'(32'd1 << tbl_bits) + 64'(idx)) << (30 - tbl_bits);
            for (int k = 19; k >= 0; k--) begin
                y = (y * y) >> 30;
                if (y >= (64'd2 << 30)) begin
                    res[k] = 1'b1;
                    y = y >> 1;
                end
            end
        end
        return res;
    endfunction

endpackage

// File: rtl/core/rgblab_log_lane.sv
// ----------------------------------------------------------------------------
// rgblab_log_lane
// One LMS channel: scale, floor, leading-one normalize, interpolated log2
// lookup and log10 scaling, eight register stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgblab_log_lane #(
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_vld,
    input  rgblab_pkg::sum_t  sum,
    input  rgblab_pkg::lms_t  lms_floor,
    output logic              out_vld,
    output rgblab_pkg::lg_t   lg
);

    localparam int RB        = rgblab_pkg::FRAC_W - LOG_TABLE_BITS;
    localparam int TBL_DEPTH = 1 << LOG_TABLE_BITS;
    localparam int IDX_W     = LOG_TABLE_BITS + 1;
    localparam int IP_W      = rgblab_pkg::ROM_W + RB;
    localparam int ST_V      = 2;
    localparam int ST_L2     = 5;
    localparam int ST_LG     = 7;

    rgblab_pkg::rom_t rom_tbl [TBL_DEPTH+1];

    for (genvar gi = 0; gi <= TBL_DEPTH; gi++) begin : g_rom
        assign rom_tbl[gi] = rgblab_pkg::log2_rom_entry(gi, LOG_TABLE_BITS);
    end

    logic [rgblab_pkg::LANE_STAGES-1:0] vld_reg, vld_next;

    rgblab_pkg::tnum_t  t1_reg, t1_next, t2_reg, t2_next;
    rgblab_pkg::qe_t    qe1_reg, qe1_next, qe2_reg, qe2_next;
    rgblab_pkg::dprod_t dp_reg, dp_next;
    rgblab_pkg::lms_t   v_reg, v_next;
    rgblab_pkg::pos_t   p4_reg, p4_next, p5_reg, p5_next;
    rgblab_pkg::frac_t  f_reg, f_next;
    rgblab_pkg::rom_t   lo_reg, lo_next, diff_reg, diff_next;
    logic [RB-1:0]      frem_reg, frem_next;
    rgblab_pkg::l2_t    l2_reg, l2_next;
    rgblab_pkg::lp_t    lp_reg, lp_next;
    rgblab_pkg::lg_t    lg_reg, lg_next;

    rgblab_pkg::qprod_t qp;
    rgblab_pkg::dprod_t rem;
    rgblab_pkg::qe_t    q;
    rgblab_pkg::lms_t   qc;
    rgblab_pkg::lms_t   norm;
    logic [IDX_W-1:0]   idx;
    rgblab_pkg::rom_t   hi;
    logic [IP_W-1:0]    ip;
    rgblab_pkg::rom_t   frac;
    rgblab_pkg::lp_t    lr;

    always_comb
    begin
        vld_next = {vld_reg[rgblab_pkg::LANE_STAGES-2:0], in_vld};

        // scale to Q16 by reciprocal estimate
        t1_next  = (rgblab_pkg::tnum_t'(sum) << rgblab_pkg::T_SH) + rgblab_pkg::DIV_OFS;
        qp       = rgblab_pkg::qprod_t'(t1_next[rgblab_pkg::T_W-1:rgblab_pkg::TRUNC_SH])
                 * rgblab_pkg::DIV_RECIP;
        qe1_next = qp[rgblab_pkg::QP_W-1:rgblab_pkg::RECIP_SH];

        dp_next  = rgblab_pkg::dprod_t'(qe1_reg) * rgblab_pkg::DIV_D;
        t2_next  = t1_reg;
        qe2_next = qe1_reg;

        // correct the estimate, clamp, apply floor
        rem = rgblab_pkg::dprod_t'(t2_reg) - dp_reg;
        q   = qe2_reg + rgblab_pkg::qe_t'(rem >= rgblab_pkg::DIV_D);
        if (q > rgblab_pkg::qe_t'(rgblab_pkg::LMS_MAX)) begin
            qc = rgblab_pkg::LMS_MAX;
        end
        else begin
            qc = q[rgblab_pkg::LMS_W-1:0];
        end
        v_next = (qc < lms_floor) ? lms_floor : qc;

        // normalize to the leading one
        p4_next = '0;
        for (int i = 1; i < rgblab_pkg::LMS_W; i++) begin
            if (v_reg[i]) begin
                p4_next = rgblab_pkg::pos_t'(i);
            end
        end
        norm   = v_reg << (rgblab_pkg::pos_t'(rgblab_pkg::LMS_W - 1) - p4_next);
        f_next = norm[rgblab_pkg::FRAC_W-1:0];

        // table lookup
        idx       = IDX_W'(f_reg[rgblab_pkg::FRAC_W-1:RB]);
        lo_next   = rom_tbl[idx];
        hi        = rom_tbl[idx + IDX_W'(1)];
        diff_next = hi - lo_next;
        frem_next = f_reg[RB-1:0];
        p5_next   = p4_reg;

        // interpolate, add exponent
        ip      = IP_W'(diff_reg) * IP_W'(frem_reg) + (IP_W'(1) << (RB - 1));
        frac    = lo_reg + rgblab_pkg::rom_t'(ip >> RB);
        l2_next = ((rgblab_pkg::l2_t'(p5_reg) - rgblab_pkg::l2_t'(rgblab_pkg::LMS_W))
                  <<< rgblab_pkg::Q_FRAC) + rgblab_pkg::l2_t'(frac);

        // scale by log10(2)
        lp_next = rgblab_pkg::lp_t'(l2_reg) * rgblab_pkg::lp_t'(rgblab_pkg::LOG10_2_Q20);

        lr      = lp_reg + (rgblab_pkg::lp_t'(1) <<< (rgblab_pkg::Q_FRAC - 1));
        lg_next = lr[rgblab_pkg::Q_FRAC +: rgblab_pkg::LG_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg <= '0;
        end
        else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t1_reg   <= t1_next;
        qe1_reg  <= qe1_next;
        t2_reg   <= t2_next;
        qe2_reg  <= qe2_next;
        dp_reg   <= dp_next;
        v_reg    <= v_next;
        p4_reg   <= p4_next;
        f_reg    <= f_next;
        p5_reg   <= p5_next;
        lo_reg   <= lo_next;
        diff_reg <= diff_next;
        frem_reg <= frem_next;
        l2_reg   <= l2_next;
        lp_reg   <= lp_next;
        lg_reg   <= lg_next;
    end

    assign out_vld = vld_reg[rgblab_pkg::LANE_STAGES-1];
    assign lg      = lg_reg;

    a_v_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_V] |-> (v_reg != '0))
        else $error("floored LMS value is zero");

    a_l2_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_L2] |-> (l2_reg <= 0))
        else $error("log2 of a value below one is positive");

    a_lg_nonpos: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_LG] |-> (lg_reg <= 0))
        else $error("log10 of a value below one is positive");

endmodule

// File: rtl/core/rgb_to_lab_log_converter.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_log_converter
// done rises for each taken start once its pixel has passed every pipeline register.
// Throughput: one pixel per clock; busy stays low, every start is a transaction.
// The 12-stage register pipeline (three LMS log lanes plus mix and round)
// sets the latency. Reset clears all valid bits and loads lms_floor with 4588.
// Results cannot be stalled: each is shown for one cycle with done.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_lab_log_converter #(
    parameter int OUT_FRAC_BITS  = 12,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    output logic                    busy,
    input  logic [7:0]              blue,
    input  logic [7:0]              green,
    input  logic [7:0]              red,
    input  logic                    cfg_we,
    input  logic [15:0]             cfg_wdata,
    output logic                    done,
    output logic signed [15:0]      lightness,
    output logic signed [15:0]      alpha,
    output logic signed [15:0]      beta
);

    localparam int RND_SH = 2 * rgblab_pkg::Q_FRAC - OUT_FRAC_BITS;
    localparam rgblab_pkg::mix_t RND_HALF = rgblab_pkg::mix_t'(1) <<< (RND_SH - 1);
    localparam rgblab_pkg::mix_t SAT_HI   = rgblab_pkg::mix_t'(rgblab_pkg::OUT_MAX);
    localparam rgblab_pkg::mix_t SAT_LO   = rgblab_pkg::mix_t'(rgblab_pkg::OUT_MIN);

    rgblab_pkg::lms_t floor_reg, floor_next;
    rgblab_pkg::lms_t floor_eff;

    logic in_vld_reg, in_vld_next;
    logic mxs_vld_reg, mxs_vld_next;
    logic mix_vld_reg, mix_vld_next;
    logic done_reg, done_next;

    rgblab_pkg::sum_t sum_reg [rgblab_pkg::NUM_CH];
    rgblab_pkg::sum_t sum_next [rgblab_pkg::NUM_CH];
    rgblab_pkg::mxs_t mxs_reg [rgblab_pkg::NUM_CH];
    rgblab_pkg::mxs_t mxs_next [rgblab_pkg::NUM_CH];
    rgblab_pkg::mix_t mix_reg [rgblab_pkg::NUM_CH];
    rgblab_pkg::mix_t mix_next [rgblab_pkg::NUM_CH];
    rgblab_pkg::out_t out_reg [rgblab_pkg::NUM_CH];
    rgblab_pkg::out_t out_next [rgblab_pkg::NUM_CH];

    logic [rgblab_pkg::NUM_CH-1:0] lane_vld;
    rgblab_pkg::lg_t               lane_lg [rgblab_pkg::NUM_CH];
    rgblab_pkg::mix_t              rq;

    assign busy      = 1'b0;
    assign floor_eff = (floor_reg == '0) ? rgblab_pkg::lms_t'(1) : floor_reg;

    for (genvar gc = 0; gc < rgblab_pkg::NUM_CH; gc++) begin : g_lane
        rgblab_log_lane #(
            .LOG_TABLE_BITS (LOG_TABLE_BITS)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_vld    (in_vld_reg),
            .sum       (sum_reg[gc]),
            .lms_floor (floor_eff),
            .out_vld   (lane_vld[gc]),
            .lg        (lane_lg[gc])
        );
    end

    always_comb
    begin
        floor_next   = cfg_we ? cfg_wdata : floor_reg;
        in_vld_next  = start && !busy;
        mxs_vld_next = &lane_vld;
        mix_vld_next = mxs_vld_reg;
        done_next    = mix_vld_reg;

        // weighted RGB sums per LMS row
        for (int c = 0; c < rgblab_pkg::NUM_CH; c++) begin
            sum_next[c] = rgblab_pkg::sum_t'(rgblab_pkg::LMS_COEF[c][0]) * rgblab_pkg::sum_t'(red)
                        + rgblab_pkg::sum_t'(rgblab_pkg::LMS_COEF[c][1]) * rgblab_pkg::sum_t'(green)
                        + rgblab_pkg::sum_t'(rgblab_pkg::LMS_COEF[c][2]) * rgblab_pkg::sum_t'(blue);
        end

        // l-alpha-beta mix
        mxs_next[0] = rgblab_pkg::mxs_t'(lane_lg[0]) + rgblab_pkg::mxs_t'(lane_lg[1])
                    + rgblab_pkg::mxs_t'(lane_lg[2]);
        mxs_next[1] = rgblab_pkg::mxs_t'(lane_lg[0]) + rgblab_pkg::mxs_t'(lane_lg[1])
                    - (rgblab_pkg::mxs_t'(lane_lg[2]) <<< 1);
        mxs_next[2] = rgblab_pkg::mxs_t'(lane_lg[0]) - rgblab_pkg::mxs_t'(lane_lg[1]);

        for (int c = 0; c < rgblab_pkg::NUM_CH; c++) begin
            mix_next[c] = rgblab_pkg::mix_t'(mxs_reg[c])
                        * rgblab_pkg::mix_t'(rgblab_pkg::MIX_COEF[c]);
        end

        // round to nearest, saturate
        rq = '0;
        for (int c = 0; c < rgblab_pkg::NUM_CH; c++) begin
            rq = (mix_reg[c] + RND_HALF) >>> RND_SH;
            if (rq > SAT_HI) begin
                out_next[c] = rgblab_pkg::OUT_MAX;
            end
            else if (rq < SAT_LO) begin
                out_next[c] = rgblab_pkg::OUT_MIN;
            end
            else begin
                out_next[c] = rq[rgblab_pkg::OUT_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            floor_reg   <= rgblab_pkg::FLOOR_RESET;
            in_vld_reg  <= 1'b0;
            mxs_vld_reg <= 1'b0;
            mix_vld_reg <= 1'b0;
            done_reg    <= 1'b0;
        end
        else begin
            floor_reg   <= floor_next;
            in_vld_reg  <= in_vld_next;
            mxs_vld_reg <= mxs_vld_next;
            mix_vld_reg <= mix_vld_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        mxs_reg <= mxs_next;
        mix_reg <= mix_next;
        out_reg <= out_next;
    end

    assign done      = done_reg;
    assign lightness = out_reg[0];
    assign alpha     = out_reg[1];
    assign beta      = out_reg[2];

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(rgblab_pkg::LATENCY) done)
        else $error("transaction did not produce a result on time");

    a_done_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, rgblab_pkg::LATENCY))
        else $error("result without a matching transaction");

    a_lane_sync: assert property (@(posedge clk) disable iff (!rst_n)
        (lane_vld[0] == lane_vld[1]) && (lane_vld[1] == lane_vld[2]))
        else $error("LMS lanes out of step");

endmodule

// File: test/rgb_to_lab_log_converter_chk.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_log_converter_chk
// Watches the pixel, configuration and result channels of the converter.
// Predicts the l-alpha-beta result of every accepted pixel from the floor
// register in force at that time, then compares each done strobe against
// the oldest pending prediction field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_lab_log_converter_chk #(
    parameter int OUT_FRAC_BITS  = 12,
    parameter int LOG_TABLE_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [7:0]         blue,
    input  logic [7:0]         green,
    input  logic [7:0]         red,
    input  logic               cfg_we,
    input  logic [15:0]        cfg_wdata,
    input  logic               done,
    input  logic signed [15:0] lightness,
    input  logic signed [15:0] alpha,
    input  logic signed [15:0] beta,
    output int                 outstanding,
    output int                 errors
);

    localparam int     RB          = 15 - LOG_TABLE_BITS;
    localparam int     MANT_LAST   = 1 << LOG_TABLE_BITS;
    localparam longint SCALE_DEN   = 2550000;
    localparam longint LOG10_OF_2  = 315653;
    localparam longint INV_SQRT3   = 605396;
    localparam longint INV_SQRT6   = 428079;
    localparam longint INV_SQRT2   = 741455;
    localparam logic [15:0] FLOOR_AT_RESET = 16'd4588;

    // rows L, M, S; columns red, green, blue
    localparam longint CONE_COEF [3][3] = '{
        '{3811, 5783, 402},
        '{1967, 7244, 782},
        '{241,  1288, 8444}
    };

    typedef struct packed {
        logic signed [15:0] lightness;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } lab_t;

    longint      log2_mant [0:MANT_LAST];
    lab_t        lab_q [$];
    logic [15:0] floor_q;

    initial begin : build_log2_mant
        longint unsigned y;
        longint          acc;
        for (int i = 0; i <= MANT_LAST; i++) begin
            if (i == MANT_LAST) begin
                log2_mant[i] = longint'(1) << 20;
            end
            else begin
                y   = longint'(MANT_LAST + i) << (30 - LOG_TABLE_BITS);
                acc = 0;
                for (int k = 19; k >= 0; k--) begin
                    y = (y * y) >> 30;
                    if (y >= (longint'(2) << 30)) begin
                        acc = acc | (longint'(1) << k);
                        y   = y >> 1;
                    end
                end
                log2_mant[i] = acc;
            end
        end
    end

    function automatic longint round_shift(input longint x, input int s);
        return (x + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint log10_q20(input int unsigned v);
        int          p;
        int unsigned m;
        int unsigned f;
        int unsigned idx;
        int unsigned rem;
        longint      lo;
        longint      hi;
        longint      mant;
        longint      l2;
        p = 15;
        while (p > 0 && ((v >> p) & 1) == 0)
            p--;
        m    = (v << (15 - p)) & 32'hFFFF;
        f    = m & 32'h7FFF;
        idx  = f >> RB;
        rem  = f & ((1 << RB) - 1);
        lo   = log2_mant[idx];
        hi   = log2_mant[idx + 1];
        mant = lo + (((hi - lo) * longint'(rem) + (longint'(1) << (RB - 1))) >>> RB);
        l2   = longint'(p - 16) * (longint'(1) << 20) + mant;
        return round_shift(l2 * LOG10_OF_2, 20);
    endfunction

    function automatic logic signed [15:0] sat_out(input longint q40);
        longint r;
        r = round_shift(q40, 40 - OUT_FRAC_BITS);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return r[15:0];
    endfunction

    function automatic lab_t predict_lab(input logic [7:0] b, input logic [7:0] g,
                                         input logic [7:0] r, input logic [15:0] fl_reg);
        longint cone_sum;
        longint q;
        longint fl;
        longint lg [3];
        lab_t   res;
        fl = (fl_reg == 16'd0) ? 1 : longint'(fl_reg);
        for (int c = 0; c < 3; c++) begin
            cone_sum = CONE_COEF[c][0] * longint'(r) + CONE_COEF[c][1] * longint'(g)
                     + CONE_COEF[c][2] * longint'(b);
            q = (cone_sum * 65536 + SCALE_DEN / 2) / SCALE_DEN;
            if (q > 65535)
                q = 65535;
            if (q < fl)
                q = fl;
            lg[c] = log10_q20(int'(q));
        end
        res.lightness = sat_out((lg[0] + lg[1] + lg[2]) * INV_SQRT3);
        res.alpha     = sat_out((lg[0] + lg[1] - 2 * lg[2]) * INV_SQRT6);
        res.beta      = sat_out((lg[0] - lg[1]) * INV_SQRT2);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        lab_t exp_lab;
        if (!rst_n) begin
            floor_q     <= FLOOR_AT_RESET;
            lab_q.delete();
            outstanding <= 0;
        end
        else begin
            if (done) begin
                if (lab_q.size() == 0) begin
                    $error("result with no pending transaction: lightness %0d alpha %0d beta %0d",
                           lightness, alpha, beta);
                    errors++;
                end
                else begin
                    exp_lab = lab_q.pop_front();
                    if (lightness !== exp_lab.lightness) begin
                        $error("lightness expected %0d actual %0d", exp_lab.lightness, lightness);
                        errors++;
                    end
                    if (alpha !== exp_lab.alpha) begin
                        $error("alpha expected %0d actual %0d", exp_lab.alpha, alpha);
                        errors++;
                    end
                    if (beta !== exp_lab.beta) begin
                        $error("beta expected %0d actual %0d", exp_lab.beta, beta);
                        errors++;
                    end
                end
            end
            if (start && !busy)
                lab_q.push_back(predict_lab(blue, green, red, floor_q));
            if (cfg_we)
                floor_q <= cfg_wdata;
            outstanding <= lab_q.size();
        end
    end

endmodule

// File: test/rgb_to_lab_log_converter_tb.sv
// ----------------------------------------------------------------------------
// rgb_to_lab_log_converter_tb
// Drives pixels into the converter: a directed set of channel extremes and
// bit patterns, then random pixels biased toward dark and saturated colors,
// over several floor settings including zero, one and full scale. A separate
// checker predicts and compares results; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rgb_to_lab_log_converter_tb;

    localparam int CYCLE_LIMIT     = 200000;
    localparam int ITEMS_PER_PHASE = 262;
    localparam int NUM_PHASES      = 7;

    // {blue, green, red}
    localparam logic [23:0] DIRECTED_PIXELS [18] = '{
        24'h000000, 24'hFFFFFF, 24'h0000FF, 24'h00FF00, 24'hFF0000, 24'hFFFF00,
        24'h00FFFF, 24'hFF00FF, 24'hAAAAAA, 24'h555555, 24'h010101, 24'h000001,
        24'h010000, 24'h808080, 24'h7F7F7F, 24'h0F0F0F, 24'hFEFEFE, 24'h123456
    };

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               start     = 1'b0;
    logic [7:0]         blue      = 8'd0;
    logic [7:0]         green     = 8'd0;
    logic [7:0]         red       = 8'd0;
    logic               cfg_we    = 1'b0;
    logic [15:0]        cfg_wdata = 16'd0;
    logic               busy;
    logic               done;
    logic signed [15:0] lightness;
    logic signed [15:0] alpha;
    logic signed [15:0] beta;
    int                 outstanding;
    int                 errors;
    int                 cycle_count = 0;

    always #1 clk = ~clk;

    rgb_to_lab_log_converter u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .lightness (lightness),
        .alpha     (alpha),
        .beta      (beta)
    );

    rgb_to_lab_log_converter_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .blue        (blue),
        .green       (green),
        .red         (red),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .done        (done),
        .lightness   (lightness),
        .alpha       (alpha),
        .beta        (beta),
        .outstanding (outstanding),
        .errors      (errors)
    );

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("rgb_to_lab_log_converter: mismatch");
            $finish;
        end
    end

    task automatic send_pixel(input logic [7:0] b, input logic [7:0] g,
                              input logic [7:0] r, input bit idle_en);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        blue  <= b;
        green <= g;
        red   <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic send_random(input bit idle_en);
        logic [7:0] b;
        logic [7:0] g;
        logic [7:0] r;
        b = 8'($urandom);
        g = 8'($urandom);
        r = 8'($urandom);
        case ($urandom_range(0, 7))
            0, 1: begin
                b = 8'($urandom_range(0, 15));
                g = 8'($urandom_range(0, 15));
                r = 8'($urandom_range(0, 15));
            end
            2: begin
                case ($urandom_range(0, 2))
                    0: b = 8'hFF;
                    1: g = 8'hFF;
                    default: r = 8'hFF;
                endcase
            end
            3: begin
                b = 8'($urandom_range(240, 255));
                g = 8'($urandom_range(240, 255));
                r = 8'($urandom_range(240, 255));
            end
            default: ;
        endcase
        send_pixel(b, g, r, idle_en);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_floor(input logic [15:0] value);
        drain();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [15:0] floor_val;
        bit          idle_en;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PIXELS[i])
            send_pixel(DIRECTED_PIXELS[i][23:16], DIRECTED_PIXELS[i][15:8],
                       DIRECTED_PIXELS[i][7:0], 1'b1);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            case (phase)
                0: floor_val = 16'd0;
                1: floor_val = 16'd1;
                2: floor_val = 16'hFFFF;
                4: floor_val = 16'($urandom_range(1, 8000));
                6: floor_val = 16'd4588;
                default: floor_val = 16'($urandom_range(1, 65535));
            endcase
            idle_en = (phase != NUM_PHASES - 1);
            set_floor(floor_val);
            send_pixel(8'h00, 8'h00, 8'h00, idle_en);
            send_pixel(8'hFF, 8'hFF, 8'hFF, idle_en);
            repeat (ITEMS_PER_PHASE)
                send_random(idle_en);
        end

        drain();
        repeat (rgblab_pkg::LATENCY + 8) @(posedge clk);
        if (errors == 0)
            $display("rgb_to_lab_log_converter: match");
        else
            $display("rgb_to_lab_log_converter: mismatch");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/rgblab_pkg.sv
rtl/core/rgblab_log_lane.sv
rtl/core/rgb_to_lab_log_converter.sv
test/rgb_to_lab_log_converter_chk.sv
test/rgb_to_lab_log_converter_tb.sv
